// File: sv/bfsp_pkg.sv
// Shared types and constants for the Bellman-Ford shortest path block.
`default_nettype none
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int WEIGHT_BITS  = 16;

  localparam int VERT_AW  = $clog2(MAX_VERTICES);
  localparam int EDGE_AW  = $clog2(MAX_EDGES);
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = EDGE_AW + 1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SOLVE  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                    mode;
    logic [VERT_AW-1:0]      edge_from;
    logic [VERT_AW-1:0]      edge_to;
    logic [WEIGHT_BITS-1:0]  edge_weight;
    logic [VERT_AW-1:0]      start_vertex;
  } cmd_t;

  typedef struct packed {
    logic [VERT_AW-1:0]      from;
    logic [VERT_AW-1:0]      to;
    logic [WEIGHT_BITS-1:0]  weight;
  } edge_t;

  typedef struct packed {
    logic                    reach;
    logic                    pred_valid;
    logic [VERT_AW-1:0]      pred;
    logic [31:0]             distance;
  } vert_t;

endpackage
`default_nettype wire

// File: sv/bfsp_front.sv
// Input side: accepts items, drops unused modes and queues commands.
`default_nettype none
module bfsp_front
  import bfsp_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  output logic                        full_o,
  input  wire logic [1:0]             mode_i,
  input  wire logic [VERT_AW-1:0]     edge_from_i,
  input  wire logic [VERT_AW-1:0]     edge_to_i,
  input  wire logic [WEIGHT_BITS-1:0] edge_weight_i,
  input  wire logic [VERT_AW-1:0]     start_vertex_i,
  output logic                        cmd_valid_o,
  output cmd_t                        cmd_o,
  input  wire logic                   cmd_pop_i
);

  cmd_t       slots_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       accept, keep, take;

  assign full_o      = (count_q == 2'd2);
  assign accept      = push_i && !full_o;
  // Mode three carries no work and is dropped here.
  assign keep        = accept && (mode_i != CMD_UNUSED);
  assign cmd_valid_o = (count_q != 2'd0);
  assign take        = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slots_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (keep) begin
      slots_q[wr_ptr_q] <= '{mode: cmd_e'(mode_i), edge_from: edge_from_i,
                             edge_to: edge_to_i, edge_weight: edge_weight_i,
                             start_vertex: start_vertex_i};
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (keep) wr_ptr_q <= ~wr_ptr_q;
      if (take) rd_ptr_q <= ~rd_ptr_q;
      if (keep && !take) count_q <= count_q + 2'd1;
      else if (!keep && take) count_q <= count_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: sv/bfsp_engine.sv
// Back end: edge storage, sorting, relaxation passes and result output.
`default_nettype none
module bfsp_engine
  import bfsp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [COUNT_W-1:0] vertex_count_i,
  input  wire logic               cmd_valid_i,
  input  wire cmd_t               cmd_i,
  output logic                    cmd_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic [VERT_AW-1:0]      vertex_index_o,
  output logic [31:0]             distance_o,
  output logic                    reachable_o,
  output logic [VERT_AW-1:0]      predecessor_o,
  output logic                    has_predecessor_o,
  output logic                    negative_cycle_o,
  output logic                    edge_overflow_o,
  output logic                    last_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INIT     = 10'b0000000010,
    S_SORT_RD  = 10'b0000000100,
    S_SORT_CHK = 10'b0000001000,
    S_R_EDGE   = 10'b0000010000,
    S_R_U      = 10'b0000100000,
    S_R_V      = 10'b0001000000,
    S_R_CALC   = 10'b0010000000,
    S_OUT_RD   = 10'b0100000000,
    S_OUT_LD   = 10'b1000000000
  } state_e;

  // Memories.
  edge_t edge_mem [MAX_EDGES];
  edge_t sort_mem [MAX_EDGES];
  vert_t vert_mem [MAX_VERTICES];
  edge_t edge_rd_q, sort_rd_q;
  vert_t vert_rd_q;

  state_e             state_q, state_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               ovf_q, ovf_d;
  logic               neg_q, neg_d;
  logic [VERT_AW-1:0] start_q, start_d;
  logic [COUNT_W-1:0] vi_q, vi_d;
  logic [TOTAL_W-1:0] k_q, k_d;
  logic [TOTAL_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] pass_q, pass_d;
  edge_t              e_q, e_d;
  vert_t              u_q, u_d;
  logic               ov_q, ov_d;

  logic [VERT_AW-1:0] out_idx_q, out_idx_d;
  vert_t              out_vert_q, out_vert_d;
  logic               out_neg_q, out_neg_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_last_q, out_last_d;

  logic [COUNT_W-1:0] n_eff;
  logic [EDGE_AW-1:0] edge_addr, sort_addr;
  logic               edge_we, sort_we, vert_we;
  edge_t              edge_wdata;
  logic [VERT_AW-1:0] vert_addr;
  vert_t              vert_wdata;
  logic signed [32:0] sum;
  logic [31:0]        cand;
  logic               relax, final_pass;

  // Effective vertex count, clamped to one through the maximum.
  always_comb begin
    if (vertex_count_i == '0) n_eff = COUNT_W'(1);
    else if (vertex_count_i > COUNT_W'(MAX_VERTICES)) n_eff = COUNT_W'(MAX_VERTICES);
    else n_eff = vertex_count_i;
  end

  // Saturated candidate distance and relax decision.
  assign sum = {u_q.distance[31], u_q.distance} +
               {{(33-WEIGHT_BITS){e_q.weight[WEIGHT_BITS-1]}}, e_q.weight};
  always_comb begin
    if (sum[32] != sum[31]) cand = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else cand = sum[31:0];
  end
  assign relax = u_q.reach &&
                 (!vert_rd_q.reach || ($signed(vert_rd_q.distance) > $signed(cand)));
  assign final_pass = (pass_q == n_eff - COUNT_W'(1));

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_addr] <= edge_wdata;
    edge_rd_q <= edge_mem[edge_addr];
  end

  always_ff @(posedge clk_i) begin
    if (sort_we) sort_mem[sort_addr] <= edge_rd_q;
    sort_rd_q <= sort_mem[sort_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vert_we) vert_mem[vert_addr] <= vert_wdata;
    vert_rd_q <= vert_mem[vert_addr];
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    ovf_d      = ovf_q;
    neg_d      = neg_q;
    start_d    = start_q;
    vi_d       = vi_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    e_d        = e_q;
    u_d        = u_q;
    ov_d       = ov_q;
    out_idx_d  = out_idx_q;
    out_vert_d = out_vert_q;
    out_neg_d  = out_neg_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;
    cmd_pop_o  = 1'b0;
    edge_we    = 1'b0;
    edge_addr  = k_q[EDGE_AW-1:0];
    edge_wdata = '{from: cmd_i.edge_from, to: cmd_i.edge_to, weight: cmd_i.edge_weight};
    sort_we    = 1'b0;
    sort_addr  = k_q[EDGE_AW-1:0];
    vert_we    = 1'b0;
    vert_addr  = vi_q[VERT_AW-1:0];
    vert_wdata = '{reach: 1'b0, pred_valid: 1'b0, pred: '0, distance: '0};

    if (pop_i && ov_q) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.mode)
            CMD_LOAD: begin
              if (total_q < TOTAL_W'(MAX_EDGES)) begin
                edge_we   = 1'b1;
                edge_addr = total_q[EDGE_AW-1:0];
                total_d   = total_q + TOTAL_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              total_d = '0;
              ovf_d   = 1'b0;
            end
            CMD_SOLVE: begin
              start_d = cmd_i.start_vertex;
              neg_d   = 1'b0;
              vi_d    = '0;
              state_d = S_INIT;
            end
            default: ;
          endcase
        end
      end

      // Clear every vertex in use; the start vertex becomes reachable.
      S_INIT: begin
        vert_we = 1'b1;
        vert_wdata.reach = (vi_q == {1'b0, start_q});
        if (vi_q + COUNT_W'(1) == n_eff) begin
          vi_d  = '0;
          k_d   = '0;
          cnt_d = '0;
          state_d = (total_q == '0) ? S_OUT_RD : S_SORT_RD;
        end else begin
          vi_d = vi_q + COUNT_W'(1);
        end
      end

      // Stable sort by source, keeping only edges whose destination is in range: one scan of the edge list per vertex.
      S_SORT_RD: state_d = S_SORT_CHK;

      S_SORT_CHK: begin
        if ({1'b0, edge_rd_q.from} == vi_q && {1'b0, edge_rd_q.to} < n_eff) begin
          sort_we   = 1'b1;
          sort_addr = cnt_q[EDGE_AW-1:0];
          cnt_d     = cnt_q + TOTAL_W'(1);
        end
        state_d = S_SORT_RD;
        if (k_q + TOTAL_W'(1) == total_q) begin
          k_d = '0;
          if (vi_q + COUNT_W'(1) == n_eff) begin
            vi_d   = '0;
            pass_d = '0;
            state_d = (cnt_d == '0) ? S_OUT_RD : S_R_EDGE;
          end else begin
            vi_d = vi_q + COUNT_W'(1);
          end
        end else begin
          k_d = k_q + TOTAL_W'(1);
        end
      end

      // Relaxation: fetch edge, then source and destination vertex.
      S_R_EDGE: state_d = S_R_U;

      S_R_U: begin
        e_d       = sort_rd_q;
        vert_addr = sort_rd_q.from;
        state_d   = S_R_V;
      end

      S_R_V: begin
        vert_addr = e_q.to;
        state_d   = S_R_CALC;
      end

      S_R_CALC: begin
        if (state_q == S_R_CALC) u_d = u_q;
        vert_addr = e_q.to;
        state_d   = S_R_EDGE;
        if (relax) begin
          vert_we    = 1'b1;
          vert_wdata = '{reach: 1'b1, pred_valid: 1'b1, pred: e_q.from, distance: cand};
        end
        if (relax && final_pass) begin
          neg_d   = 1'b1;
          vi_d    = '0;
          state_d = S_OUT_RD;
        end else if (k_q + TOTAL_W'(1) == cnt_q) begin
          k_d = '0;
          if (final_pass) begin
            vi_d    = '0;
            state_d = S_OUT_RD;
          end else begin
            pass_d = pass_q + COUNT_W'(1);
          end
        end else begin
          k_d = k_q + TOTAL_W'(1);
        end
      end

      // Result output, one vertex per transaction.
      S_OUT_RD: state_d = S_OUT_LD;

      S_OUT_LD: begin
        if (!ov_q || pop_i) begin
          ov_d       = 1'b1;
          out_idx_d  = vi_q[VERT_AW-1:0];
          out_vert_d = vert_rd_q;
          out_neg_d  = neg_q;
          out_ovf_d  = ovf_q;
          out_last_d = (vi_q + COUNT_W'(1) == n_eff);
          if (vi_q + COUNT_W'(1) == n_eff) begin
            state_d = S_IDLE;
          end else begin
            vi_d    = vi_q + COUNT_W'(1);
            state_d = S_OUT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Capture the source vertex entry when its read data arrives.
    if (state_q == S_R_V) u_d = vert_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    start_q    <= start_d;
    vi_q       <= vi_d;
    k_q        <= k_d;
    cnt_q      <= cnt_d;
    pass_q     <= pass_d;
    e_q        <= e_d;
    u_q        <= u_d;
    out_idx_q  <= out_idx_d;
    out_vert_q <= out_vert_d;
    out_neg_q  <= out_neg_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  assign empty_o           = !ov_q;
  assign vertex_index_o    = out_idx_q;
  assign distance_o        = out_vert_q.distance;
  assign reachable_o       = out_vert_q.reach;
  assign predecessor_o     = out_vert_q.pred;
  assign has_predecessor_o = out_vert_q.pred_valid;
  assign negative_cycle_o  = out_neg_q;
  assign edge_overflow_o   = out_ovf_q;
  assign last_o            = out_last_q;

endmodule
`default_nettype wire

// File: sv/bellman_ford_shortest_path_top.sv
// Top level of the Bellman-Ford shortest path block with its register port.
//
// Items enter through a queue-style port: an item is taken when push is
// high and full is low. Mode 0 appends an edge, mode 2 empties the edge
// list, mode 1 solves from start_vertex_i, mode 3 is ignored. Results leave
// through a queue-style port: the oldest result is shown while empty is
// low and is taken when pop is high.
// A solve is paced by the single-port edge and vertex memories: the sort
// scans the edge list once per vertex, and every relax reads the sorted
// edge, the source vertex and the destination vertex in turn before
// writing back. A two-entry command queue lets new items be taken while a
// solve runs. If the receiver stalls, the result register holds and the
// solve waits. Reset empties the edge list, clears the overflow flag and
// sets vertex_count to 64. vertex_count is at byte address 0 of the APB
// port, and every write to the port, at any address, lands on it.
`default_nettype none
module bellman_ford_shortest_path_top
  import bfsp_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [1:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [1:0]             mode_i,
  input  wire logic [VERT_AW-1:0]     edge_from_i,
  input  wire logic [VERT_AW-1:0]     edge_to_i,
  input  wire logic [WEIGHT_BITS-1:0] edge_weight_i,
  input  wire logic [VERT_AW-1:0]     start_vertex_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [VERT_AW-1:0]          vertex_index_o,
  output logic [31:0]                 distance_o,
  output logic                        reachable_o,
  output logic [VERT_AW-1:0]          predecessor_o,
  output logic                        has_predecessor_o,
  output logic                        negative_cycle_o,
  output logic                        edge_overflow_o,
  output logic                        last_o
);

  logic [COUNT_W-1:0] vertex_count_q;
  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;

  // Register port: one register, every write lands on it.
  assign pready = 1'b1;
  assign prdata = {{(32-COUNT_W){1'b0}}, vertex_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= COUNT_W'(MAX_VERTICES);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      vertex_count_q <= pwdata[COUNT_W-1:0];
    end else if (psel && penable && pwrite) begin
      vertex_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  bfsp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .mode_i         (mode_i),
    .edge_from_i    (edge_from_i),
    .edge_to_i      (edge_to_i),
    .edge_weight_i  (edge_weight_i),
    .start_vertex_i (start_vertex_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  bfsp_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vertex_count_i    (vertex_count_q),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_pop_o         (cmd_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .vertex_index_o    (vertex_index_o),
    .distance_o        (distance_o),
    .reachable_o       (reachable_o),
    .predecessor_o     (predecessor_o),
    .has_predecessor_o (has_predecessor_o),
    .negative_cycle_o  (negative_cycle_o),
    .edge_overflow_o   (edge_overflow_o),
    .last_o            (last_o)
  );

endmodule
`default_nettype wire
